// File: hw/rtl/tdtod_pkg.sv
// Shared types and constants for the tick-driven time-of-day clock.
// No dependencies; used by every module in hw/rtl.
package tdtod_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_e;

  typedef enum logic {
    CFG_TICKS_PER_SECOND = 1'b0,
    CFG_TICKS_PER_SLICE  = 1'b1
  } cfg_idx_e;

  localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
  localparam logic [15:0] TICKS_PER_SLICE_RST  = 16'd10;

  localparam logic [5:0] LAST_SEC_MIN   = 6'd59;
  localparam logic [3:0] HOUR_NOON      = 4'd12;
  localparam logic [3:0] HOUR_BEFORE_12 = 4'd11;
  localparam logic [3:0] HOUR_ONE       = 4'd1;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic       binary_format;
  } item_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [3:0] hour;
    logic       pm;
  } tod_t;

  typedef struct packed {
    tod_t        tod;
    logic        second_changed;
    logic        slice_end;
    logic [31:0] tick_count;
  } result_t;

endpackage

// File: hw/rtl/tdtod_load_conv.sv
// Converts raw clock-chip bytes (BCD or binary) into 12-hour time of day.
// Depends on tdtod_pkg.
module tdtod_load_conv (
  input  tdtod_pkg::item_t item_i,
  output tdtod_pkg::tod_t  tod_o
);

  logic [7:0]  sec_val, min_val;
  logic [6:0]  hour_val;
  logic [7:0]  hour_off;
  logic [15:0] hour_prod;
  logic [3:0]  hour_quo;
  logic [7:0]  hour_rem;

  // tens digit times ten as two shifts
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return {4'd0, b[3:0]} + (tens << 3) + (tens << 1);
  endfunction

  always_comb begin
    if (item_i.binary_format) begin
      sec_val  = item_i.raw_second;
      min_val  = item_i.raw_minute;
      hour_val = item_i.raw_hour[6:0];
    end else begin
      sec_val  = bcd_to_bin(item_i.raw_second);
      min_val  = bcd_to_bin(item_i.raw_minute);
      hour_val = 7'({4'd0, item_i.raw_hour[3:0]} + ({4'd0, item_i.raw_hour[6:4]} << 3)
                    + ({4'd0, item_i.raw_hour[6:4]} << 1));
    end
  end

  // (h + 11) mod 12 via reciprocal 171/2048; exact for h + 11 <= 138
  assign hour_off  = {1'b0, hour_val} + 8'd11;
  assign hour_prod = 16'(hour_off) * 16'd171;
  assign hour_quo  = hour_prod[14:11];
  assign hour_rem  = hour_off - ({4'd0, hour_quo} << 3) - ({4'd0, hour_quo} << 2);

  assign tod_o.second = (sec_val > 8'(tdtod_pkg::LAST_SEC_MIN)) ? tdtod_pkg::LAST_SEC_MIN
                                                                 : sec_val[5:0];
  assign tod_o.minute = (min_val > 8'(tdtod_pkg::LAST_SEC_MIN)) ? tdtod_pkg::LAST_SEC_MIN
                                                                 : min_val[5:0];
  assign tod_o.hour   = hour_rem[3:0] + 4'd1;
  assign tod_o.pm     = item_i.raw_hour[7] | (hour_val > 7'(tdtod_pkg::HOUR_NOON));

endmodule

// File: hw/rtl/tdtod_time_core.sv
// Time-of-day state: tick counter, second and slice prescalers, 12-hour cascade.
// Depends on tdtod_pkg; fed by tdtod_load_conv for load beats.
module tdtod_time_core #(
  parameter int TICK_COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  tdtod_pkg::item_t    item_i,
  input  tdtod_pkg::tod_t     load_i,
  input  logic [15:0]         ticks_per_second_i,
  input  logic [15:0]         ticks_per_slice_i,
  output tdtod_pkg::result_t  result_o
);

  logic [TICK_COUNT_WIDTH-1:0] total_q, total_d;
  logic [15:0] sec_pre_q, sec_pre_d, sec_pre_inc;
  logic [15:0] slc_pre_q, slc_pre_d, slc_pre_inc;
  tdtod_pkg::tod_t tod_q, tod_d;
  logic changed, slice;

  assign sec_pre_inc = sec_pre_q + 16'd1;
  assign slc_pre_inc = slc_pre_q + 16'd1;

  always_comb begin
    total_d   = total_q;
    sec_pre_d = sec_pre_q;
    slc_pre_d = slc_pre_q;
    tod_d     = tod_q;
    changed   = 1'b0;
    slice     = 1'b0;
    if (go_i) begin
      unique case (item_i.opcode)
        tdtod_pkg::OP_LOAD: begin
          tod_d   = load_i;
          changed = 1'b1;
        end
        tdtod_pkg::OP_TICK: begin
          total_d = total_q + TICK_COUNT_WIDTH'(1);
          if (sec_pre_inc >= ticks_per_second_i) begin
            sec_pre_d = '0;
            changed   = 1'b1;
            if (tod_q.second == tdtod_pkg::LAST_SEC_MIN) begin
              tod_d.second = '0;
              if (tod_q.minute == tdtod_pkg::LAST_SEC_MIN) begin
                tod_d.minute = '0;
                if (tod_q.hour == tdtod_pkg::HOUR_BEFORE_12) begin
                  tod_d.hour = tdtod_pkg::HOUR_NOON;
                  tod_d.pm   = ~tod_q.pm;
                end else if (tod_q.hour >= tdtod_pkg::HOUR_NOON) begin
                  tod_d.hour = tdtod_pkg::HOUR_ONE;
                end else begin
                  tod_d.hour = tod_q.hour + 4'd1;
                end
              end else begin
                tod_d.minute = tod_q.minute + 6'd1;
              end
            end else begin
              tod_d.second = tod_q.second + 6'd1;
            end
          end else begin
            sec_pre_d = sec_pre_inc;
          end
          // a period below the running count fires at once
          if (slc_pre_inc >= ticks_per_slice_i) begin
            slc_pre_d = '0;
            slice     = 1'b1;
          end else begin
            slc_pre_d = slc_pre_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      sec_pre_q   <= '0;
      slc_pre_q   <= '0;
      tod_q.second <= '0;
      tod_q.minute <= '0;
      tod_q.hour   <= tdtod_pkg::HOUR_NOON;
      tod_q.pm     <= 1'b0;
    end else begin
      total_q   <= total_d;
      sec_pre_q <= sec_pre_d;
      slc_pre_q <= slc_pre_d;
      tod_q     <= tod_d;
    end
  end

  assign result_o.tod            = tod_d;
  assign result_o.second_changed = changed;
  assign result_o.slice_end      = slice;
  assign result_o.tick_count     = 32'(total_d);

`ifndef SYNTHESIS
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.opcode == tdtod_pkg::OP_TICK |=>
      total_q == $past(total_q) + TICK_COUNT_WIDTH'(1))
    else $error("tick beat did not advance tick counter");
  a_load_keeps_prescale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.opcode == tdtod_pkg::OP_LOAD |=>
      $stable(total_q) && $stable(sec_pre_q) && $stable(slc_pre_q))
    else $error("load beat disturbed counters");
  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tod_q.second <= tdtod_pkg::LAST_SEC_MIN && tod_q.minute <= tdtod_pkg::LAST_SEC_MIN &&
    tod_q.hour >= tdtod_pkg::HOUR_ONE && tod_q.hour <= tdtod_pkg::HOUR_NOON)
    else $error("time of day out of range");
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go_i |=> $stable(tod_q) && $stable(total_q))
    else $error("state changed without a beat");
`endif

endmodule

// File: hw/rtl/tick_driven_time_of_day_clock.sv
// Top level of the tick-driven 12-hour time-of-day clock: config registers,
// input register, output register. Depends on tdtod_pkg, tdtod_load_conv, tdtod_time_core.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tdata: sec, min, hour; tuser: opcode, binary
//   m_axis    out  tvalid/tready             tdata: time, flags, tick count
//   cfg       in   cfg_we_i (no backpressure) cfg_index_i, cfg_wdata_i
//
// One beat per clock sustained while m_axis_tready_i is high; a beat passes through the
// input register, then the core's combinational update into the output register.
// Reset (async, active low) clears both valid flags, sets 12:00:00 AM, zero
// counters, and the period registers to 1000 and 10 ticks.
// A stall on m_axis_tready_i reaches s_axis_tready_o in the same cycle; the
// input register keeps one beat while the result waits.
module tick_driven_time_of_day_clock #(
  parameter int TICK_COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] raw_second, [15:8] raw_minute, [23:16] raw_hour
  input  logic [23:0] s_axis_tdata_i,
  // [0] opcode, [1] binary_format
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [5:0] out_second, [11:6] out_minute, [15:12] out_hour, [16] out_pm,
  // [17] second_changed, [18] slice_end, [50:19] tick_count, [55:51] zero
  output logic [55:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] tps_q, tsl_q;
  logic in_valid_q, out_valid_q, out_free, go, s_accept;
  tdtod_pkg::item_t   in_item_q, s_item;
  tdtod_pkg::tod_t    load_tod;
  tdtod_pkg::result_t result, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= tdtod_pkg::TICKS_PER_SECOND_RST;
      tsl_q <= tdtod_pkg::TICKS_PER_SLICE_RST;
    end else if (cfg_we_i) begin
      unique case (tdtod_pkg::cfg_idx_e'(cfg_index_i))
        tdtod_pkg::CFG_TICKS_PER_SECOND: tps_q <= cfg_wdata_i;
        tdtod_pkg::CFG_TICKS_PER_SLICE:  tsl_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign go              = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign s_item.opcode        = tdtod_pkg::opcode_e'(s_axis_tuser_i[0]);
  assign s_item.binary_format = s_axis_tuser_i[1];
  assign s_item.raw_second    = s_axis_tdata_i[7:0];
  assign s_item.raw_minute    = s_axis_tdata_i[15:8];
  assign s_item.raw_hour      = s_axis_tdata_i[23:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (go) begin
        in_valid_q <= 1'b0;
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= s_item;
    end
    if (go) begin
      out_q <= result;
    end
  end

  tdtod_load_conv u_load_conv (
    .item_i (in_item_q),
    .tod_o  (load_tod)
  );

  tdtod_time_core #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_time_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .go_i               (go),
    .item_i             (in_item_q),
    .load_i             (load_tod),
    .ticks_per_second_i (tps_q),
    .ticks_per_slice_i  (tsl_q),
    .result_o           (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.tick_count, out_q.slice_end, out_q.second_changed,
                            out_q.tod.pm, out_q.tod.hour, out_q.tod.minute, out_q.tod.second};

endmodule

// File: tb/tb_tick_driven_time_of_day_clock.sv
// Self-checking testbench for tick_driven_time_of_day_clock: ticks and time loads
// streamed in, every result beat checked against an in-bench 12-hour clock model.
// Depends on tdtod_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_tick_driven_time_of_day_clock;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    int unsigned second;
    int unsigned minute;
    int unsigned hour;
    bit          pm;
    bit          changed;
    bit          slice_end;
    logic [31:0] ticks;
  } tod_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  tick_driven_time_of_day_clock dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clock model state, mirrors the block after reset
  int unsigned per_second = tdtod_pkg::TICKS_PER_SECOND_RST;
  int unsigned per_slice  = tdtod_pkg::TICKS_PER_SLICE_RST;
  int unsigned sec_div    = 0;
  int unsigned slice_div  = 0;
  int unsigned tod_sec    = 0;
  int unsigned tod_min    = 0;
  int unsigned tod_hour   = 12;
  bit          tod_pm     = 1'b0;
  logic [31:0] tick_total = '0;

  tdtod_pkg::item_t pending_items[$];
  tod_report_t      expected_times[$];
  tdtod_pkg::item_t cur_item;
  int          errors = 0;
  int          results_seen = 0;
  int          cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic int unsigned bcd_value(logic [7:0] b);
    return int'(b[3:0]) + int'(b[7:4]) * 10;
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned v);
    logic [3:0] tens;
    logic [3:0] ones;
    tens = 4'(v / 10);
    ones = 4'(v % 10);
    return {tens, ones};
  endfunction

  // Applies one item to the clock model and returns the time report it yields
  function automatic tod_report_t advance_tod(tdtod_pkg::item_t it);
    tod_report_t r;
    int unsigned s;
    int unsigned m;
    int unsigned h;
    r.changed = 1'b0;
    r.slice_end = 1'b0;
    if (it.opcode == tdtod_pkg::OP_LOAD) begin
      if (it.binary_format) begin
        s = it.raw_second;
        m = it.raw_minute;
        h = it.raw_hour[6:0];
      end else begin
        s = bcd_value(it.raw_second);
        m = bcd_value(it.raw_minute);
        h = int'(it.raw_hour[3:0]) + int'(it.raw_hour[6:4]) * 10;
      end
      tod_sec = (s > 59) ? 59 : s;
      tod_min = (m > 59) ? 59 : m;
      tod_pm = it.raw_hour[7] || (h > 12);
      tod_hour = ((h + 11) % 12) + 1;
      r.changed = 1'b1;
    end else begin
      tick_total = tick_total + 32'd1;
      sec_div++;
      if (sec_div >= per_second) begin
        sec_div = 0;
        r.changed = 1'b1;
        tod_sec++;
        if (tod_sec >= 60) begin
          tod_sec = 0;
          tod_min++;
          if (tod_min >= 60) begin
            tod_min = 0;
            // meridiem flips on the way into twelve
            if (tod_hour == 11) begin
              tod_hour = 12;
              tod_pm = ~tod_pm;
            end else if (tod_hour >= 12) begin
              tod_hour = 1;
            end else begin
              tod_hour++;
            end
          end
        end
      end
      slice_div++;
      if (slice_div >= per_slice) begin
        slice_div = 0;
        r.slice_end = 1'b1;
      end
    end
    r.second = tod_sec;
    r.minute = tod_min;
    r.hour = tod_hour;
    r.pm = tod_pm;
    r.ticks = tick_total;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tdtod_pkg::item_t make_item(tdtod_pkg::opcode_e op, logic [7:0] sec,
                                                 logic [7:0] min, logic [7:0] hour,
                                                 logic bin);
    tdtod_pkg::item_t it;
    it.opcode = op;
    it.raw_second = sec;
    it.raw_minute = min;
    it.raw_hour = hour;
    it.binary_format = bin;
    return it;
  endfunction

  function automatic tdtod_pkg::item_t random_item();
    tdtod_pkg::item_t it;
    bit near;
    bit pm_bit;
    int unsigned s;
    int unsigned m;
    int unsigned h;
    it = make_item(tdtod_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom));
    if ($urandom_range(0, 99) < 80) return it;
    it.opcode = tdtod_pkg::OP_LOAD;
    if ($urandom_range(0, 3) == 0) return it;  // arbitrary bytes
    near = $urandom_range(0, 1);
    pm_bit = $urandom_range(0, 1);
    s = near ? $urandom_range(50, 59) : $urandom_range(0, 59);
    m = near ? 59 : $urandom_range(0, 59);
    h = near ? $urandom_range(11, 12) : $urandom_range(0, 23);
    if (it.binary_format) begin
      it.raw_second = 8'(s);
      it.raw_minute = 8'(m);
      it.raw_hour = {pm_bit, 7'(h)};
    end else begin
      it.raw_second = to_bcd(s);
      it.raw_minute = to_bcd(m);
      it.raw_hour = to_bcd(h) | {pm_bit, 7'd0};
    end
    return it;
  endfunction

  // Input side: one beat per item, random gaps between beats if tx_idle_on
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) expected_times.push_back(advance_tod(cur_item));
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        s_tdata <= {cur_item.raw_hour, cur_item.raw_minute, cur_item.raw_second};
        s_tuser <= {cur_item.binary_format, cur_item.opcode};
        s_tvalid <= 1'b1;
        if (tx_idle_on) tx_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side ready: random stalls plus one long hold-off to back up the block
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 400) begin
      hold_done = 1'b1;
      hold_left = 500;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (rx_idle_on) rx_stall = pick_gap();
    end
  end

  task automatic check_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tod_report_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_times.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_times.pop_front();
        check_field("second", want.second, m_tdata[5:0]);
        check_field("minute", want.minute, m_tdata[11:6]);
        check_field("hour", want.hour, m_tdata[15:12]);
        check_field("pm", want.pm, m_tdata[16]);
        check_field("second_changed", want.changed, m_tdata[17]);
        check_field("slice_end", want.slice_end, m_tdata[18]);
        check_field("tick_count", want.ticks, m_tdata[50:19]);
        check_field("pad", 0, m_tdata[55:51]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_times.size());
      $display("tb_tick_driven_time_of_day_clock failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_tvalid || expected_times.size() != 0);
  endtask

  task automatic write_reg(tdtod_pkg::cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == tdtod_pkg::CFG_TICKS_PER_SECOND) per_second = val;
    else per_slice = val;
  endtask

  task automatic run_phase(logic [15:0] tps, logic [15:0] tpsl, int n, bit tx_idle,
                           bit rx_idle);
    wait_idle();
    write_reg(tdtod_pkg::CFG_TICKS_PER_SECOND, tps);
    write_reg(tdtod_pkg::CFG_TICKS_PER_SLICE, tpsl);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    repeat (n) pending_items.push_back(random_item());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset state and periods, raw fields ignored on ticks
    repeat (3) begin
      pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    end
    wait_idle();
    write_reg(tdtod_pkg::CFG_TICKS_PER_SECOND, 16'd1);
    write_reg(tdtod_pkg::CFG_TICKS_PER_SLICE, 16'd2);
    // BCD loads, 11->12 meridiem flip, 12->1 wrap, clamping, PM from bit 7 or >12
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h59, 8'h59, 8'h11, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'hA5, 8'h5A, 8'hC3, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h59, 8'h59, 8'h92, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h59, 8'h59, 8'h91, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h99, 8'hFF, 8'h7F, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h60, 8'h5A, 8'h13, 1'b0));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'h00, 8'h00, 8'h12, 1'b0));
    // binary loads
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'd59, 8'd59, 8'd11, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'd60, 8'h3F, 8'h8C, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'd1, 8'd2, 8'h80, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'd30, 8'd30, 8'd12, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_LOAD, 8'd30, 8'd30, 8'd13, 1'b1));
    pending_items.push_back(make_item(tdtod_pkg::OP_TICK, 8'd0, 8'd0, 8'd0, 1'b0));

    run_phase(16'd1, 16'd1, 250, 1'b1, 1'b1);
    run_phase(16'd2, 16'd3, 250, 1'b0, 1'b0);
    // zero period behaves as one
    run_phase(16'd0, 16'd0, 150, 1'b1, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF, 200, 1'b1, 1'b1);
    // periods lowered below the running counts: both fire on the next tick
    run_phase(16'd3, 16'd2, 250, 1'b1, 1'b0);
    run_phase(16'd60, 16'd7, 250, 1'b0, 1'b1);
    run_phase(tdtod_pkg::TICKS_PER_SECOND_RST, tdtod_pkg::TICKS_PER_SLICE_RST, 200,
              1'b1, 1'b1);
    run_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 50)), 300, 1'b1, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_tick_driven_time_of_day_clock passed");
    end else begin
      $display("tb_tick_driven_time_of_day_clock failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tdtod_pkg.sv
hw/rtl/tdtod_load_conv.sv
hw/rtl/tdtod_time_core.sv
hw/rtl/tick_driven_time_of_day_clock.sv
tb/tb_tick_driven_time_of_day_clock.sv
